>>> hw/rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared widths, constants, types and the restoring-division step for the
// pll fractional factor calculator.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int TGT_W         = 32;
   localparam int SRC_W         = 32;
   localparam int N_W           = 4;
   localparam int K_W           = 25;
   localparam int FRACTION_BITS = 24;
   // quotient of rem * 10 * 2^FRACTION_BITS / src stays below 10 * 2^FRACTION_BITS
   localparam int FRAC_STEPS    = FRACTION_BITS + 4;
   localparam int INT_STEPS     = TGT_W;
   localparam int SUM_W         = FRAC_STEPS + 1;
   localparam int RECIP_W       = 31;
   localparam int RECIP_SHIFT   = 34;
   localparam int PROD_W        = SUM_W + RECIP_W;

   localparam logic [TGT_W-1:0]   N_LOW_LIMIT  = TGT_W'(6);
   localparam logic [TGT_W-1:0]   N_HIGH_LIMIT = TGT_W'(12);
   localparam logic [SUM_W-1:0]   ROUND_ADD    = SUM_W'(5);
   // ceil(2^34 / 10), exact quotient by ten for sums below 2^34 / 6
   localparam logic [RECIP_W-1:0] RECIP_TEN    = 31'd1717986919;

   typedef struct packed {
      logic             prescale;
      logic             zero_src;
      logic [SRC_W-1:0] divisor;
      logic [TGT_W-1:0] dividend;
   } div_in_type;

   typedef struct packed {
      logic                  prescale;
      logic                  zero_src;
      logic [TGT_W-1:0]      ratio;
      logic [FRAC_STEPS-1:0] scaled;
   } div_out_type;

   // one restoring step: {quotient bit, new partial remainder}
   function automatic logic [SRC_W:0] div_step(input logic [SRC_W-1:0] rem,
                                                input logic             nbit,
                                                input logic [SRC_W-1:0] divisor);
      logic [SRC_W:0] trial;
      logic [SRC_W:0] dsub;
      logic [SRC_W:0] diff;
      trial = {rem, nbit};
      dsub  = {1'b0, divisor};
      diff  = trial - dsub;
      if (trial >= dsub) begin
         return {1'b1, diff[SRC_W-1:0]};
      end else begin
         return {1'b0, trial[SRC_W-1:0]};
      end
   endfunction

endpackage

>>> hw/rtl/pfc_req_if.sv
// ----------------------------------------------------------------------------
// pfc_req_if
// Request channel: target and source frequency pair.
// ----------------------------------------------------------------------------
interface pfc_req_if;
   logic                     valid;
   logic                     ready;
   logic [pfc_pkg::TGT_W-1:0] target_freq;
   logic [pfc_pkg::SRC_W-1:0] source_freq;

   modport source (output valid, output target_freq, output source_freq, input ready);
   modport sink   (input valid, input target_freq, input source_freq, output ready);
endinterface

>>> hw/rtl/pfc_rsp_if.sv
// ----------------------------------------------------------------------------
// pfc_rsp_if
// Response channel: pll factors and status flags.
// ----------------------------------------------------------------------------
interface pfc_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   prescale_on;
   logic [pfc_pkg::N_W-1:0] n_factor;
   logic [pfc_pkg::K_W-1:0] k_fraction;
   logic                   n_out_of_range;
   logic                   zero_source_error;

   modport source (output valid, output prescale_on, output n_factor, output k_fraction,
                   output n_out_of_range, output zero_source_error, input ready);
   modport sink   (input valid, input prescale_on, input n_factor, input k_fraction,
                   input n_out_of_range, input zero_source_error, output ready);
endinterface

>>> hw/rtl/pfc_div_pipe.sv
// ----------------------------------------------------------------------------
// pfc_div_pipe
// Pipelined restoring divider: one integer quotient bit per stage, then
// one fraction quotient bit per stage for rem * 10 * 2^FRACTION_BITS / src.
// ----------------------------------------------------------------------------
module pfc_div_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  pfc_pkg::div_in_type  in_data,
   output logic                 out_valid,
   output pfc_pkg::div_out_type out_data
);

   typedef struct packed {
      logic                      prescale;
      logic                      zero_src;
      logic [pfc_pkg::SRC_W-1:0] divisor;
      logic [pfc_pkg::TGT_W-1:0] num;
      logic [pfc_pkg::TGT_W-1:0] quo;
      logic [pfc_pkg::SRC_W-1:0] rem;
   } int_stage_type;

   typedef struct packed {
      logic                           prescale;
      logic                           zero_src;
      logic [pfc_pkg::SRC_W-1:0]      divisor;
      logic [pfc_pkg::TGT_W-1:0]      ratio;
      logic [pfc_pkg::FRAC_STEPS-1:0] num;
      logic [pfc_pkg::FRAC_STEPS-1:0] quo;
      logic [pfc_pkg::SRC_W-1:0]      rem;
   } frac_stage_type;

   int_stage_type  int_stage_ff  [0:pfc_pkg::INT_STEPS];
   int_stage_type  int_stage_in  [0:pfc_pkg::INT_STEPS];
   logic           int_valid_ff  [0:pfc_pkg::INT_STEPS];
   logic           int_valid_in  [0:pfc_pkg::INT_STEPS];
   frac_stage_type frac_stage_ff [0:pfc_pkg::FRAC_STEPS];
   frac_stage_type frac_stage_in [0:pfc_pkg::FRAC_STEPS];
   logic           frac_valid_ff [0:pfc_pkg::FRAC_STEPS];
   logic           frac_valid_in [0:pfc_pkg::FRAC_STEPS];
   logic [pfc_pkg::SRC_W+3:0] rem_x10;

   always_comb begin
      int_valid_in[0]          = in_valid;
      int_stage_in[0].prescale = in_data.prescale;
      int_stage_in[0].zero_src = in_data.zero_src;
      int_stage_in[0].divisor  = in_data.divisor;
      int_stage_in[0].num      = in_data.dividend;
      int_stage_in[0].quo      = '0;
      int_stage_in[0].rem      = '0;
   end

   for (genvar i = 0; i < pfc_pkg::INT_STEPS; i++) begin : g_int
      logic [pfc_pkg::SRC_W:0] step;
      always_comb begin
         step = pfc_pkg::div_step(int_stage_ff[i].rem,
                                  int_stage_ff[i].num[pfc_pkg::TGT_W-1],
                                  int_stage_ff[i].divisor);
         int_valid_in[i+1]          = int_valid_ff[i];
         int_stage_in[i+1]          = int_stage_ff[i];
         int_stage_in[i+1].num      = {int_stage_ff[i].num[pfc_pkg::TGT_W-2:0], 1'b0};
         int_stage_in[i+1].quo      = {int_stage_ff[i].quo[pfc_pkg::TGT_W-2:0],
                                       step[pfc_pkg::SRC_W]};
         int_stage_in[i+1].rem      = step[pfc_pkg::SRC_W-1:0];
      end
   end

   // remainder times ten, top bits start the partial remainder (below src)
   always_comb begin
      rem_x10 = {int_stage_ff[pfc_pkg::INT_STEPS].rem, 3'b000}
              + {2'b00, int_stage_ff[pfc_pkg::INT_STEPS].rem, 1'b0};
      frac_valid_in[0]          = int_valid_ff[pfc_pkg::INT_STEPS];
      frac_stage_in[0].prescale = int_stage_ff[pfc_pkg::INT_STEPS].prescale;
      frac_stage_in[0].zero_src = int_stage_ff[pfc_pkg::INT_STEPS].zero_src;
      frac_stage_in[0].divisor  = int_stage_ff[pfc_pkg::INT_STEPS].divisor;
      frac_stage_in[0].ratio    = int_stage_ff[pfc_pkg::INT_STEPS].quo;
      frac_stage_in[0].num      = {rem_x10[3:0], pfc_pkg::FRACTION_BITS'(0)};
      frac_stage_in[0].quo      = '0;
      frac_stage_in[0].rem      = rem_x10[pfc_pkg::SRC_W+3:4];
   end

   for (genvar j = 0; j < pfc_pkg::FRAC_STEPS; j++) begin : g_frac
      logic [pfc_pkg::SRC_W:0] step;
      always_comb begin
         step = pfc_pkg::div_step(frac_stage_ff[j].rem,
                                  frac_stage_ff[j].num[pfc_pkg::FRAC_STEPS-1],
                                  frac_stage_ff[j].divisor);
         frac_valid_in[j+1]     = frac_valid_ff[j];
         frac_stage_in[j+1]     = frac_stage_ff[j];
         frac_stage_in[j+1].num = {frac_stage_ff[j].num[pfc_pkg::FRAC_STEPS-2:0], 1'b0};
         frac_stage_in[j+1].quo = {frac_stage_ff[j].quo[pfc_pkg::FRAC_STEPS-2:0],
                                   step[pfc_pkg::SRC_W]};
         frac_stage_in[j+1].rem = step[pfc_pkg::SRC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= pfc_pkg::INT_STEPS; i++) int_valid_ff[i] <= 1'b0;
         for (int j = 0; j <= pfc_pkg::FRAC_STEPS; j++) frac_valid_ff[j] <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i <= pfc_pkg::INT_STEPS; i++) int_valid_ff[i] <= int_valid_in[i];
         for (int j = 0; j <= pfc_pkg::FRAC_STEPS; j++) frac_valid_ff[j] <= frac_valid_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= pfc_pkg::INT_STEPS; i++) int_stage_ff[i] <= int_stage_in[i];
         for (int j = 0; j <= pfc_pkg::FRAC_STEPS; j++) frac_stage_ff[j] <= frac_stage_in[j];
      end
   end

   always_comb begin
      out_valid         = frac_valid_ff[pfc_pkg::FRAC_STEPS];
      out_data.prescale = frac_stage_ff[pfc_pkg::FRAC_STEPS].prescale;
      out_data.zero_src = frac_stage_ff[pfc_pkg::FRAC_STEPS].zero_src;
      out_data.ratio    = frac_stage_ff[pfc_pkg::FRAC_STEPS].ratio;
      out_data.scaled   = frac_stage_ff[pfc_pkg::FRAC_STEPS].quo;
   end

endmodule

>>> hw/rtl/pll_fractional_factor_calc.sv
// ----------------------------------------------------------------------------
// pll_fractional_factor_calc
// Fractional-N pll factors (prescale, N, K) from a target/source pair.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | target_freq, source_freq
//  rsp     | out | valid/ready | prescale_on, n_factor, k_fraction,
//          |     |             | n_out_of_range, zero_source_error
//
// one transaction per cycle sustained while rsp.ready stays high; each result passes
// the one-bit-per-stage divider chain, then the round, multiply and response registers
// synchronous reset clears only valid bits; no clearing pass
// a waiting response freezes the whole pipeline and drops req.ready
// ----------------------------------------------------------------------------
module pll_fractional_factor_calc (
   input logic    clock,
   input logic    reset,
   pfc_req_if.sink   req_chan,
   pfc_rsp_if.source rsp_chan
);

   typedef struct packed {
      logic                          prescale;
      logic                          zero_src;
      logic [pfc_pkg::TGT_W-1:0]     ratio;
      logic [pfc_pkg::SUM_W-1:0]     sum;
   } rnd_stage_type;

   typedef struct packed {
      logic                          prescale;
      logic                          zero_src;
      logic [pfc_pkg::TGT_W-1:0]     ratio;
      logic [pfc_pkg::PROD_W-1:0]    prod;
   } mul_stage_type;

   typedef struct packed {
      logic                    prescale_on;
      logic [pfc_pkg::N_W-1:0] n_factor;
      logic [pfc_pkg::K_W-1:0] k_fraction;
      logic                    n_out_of_range;
      logic                    zero_source_error;
   } rsp_type;

   logic                 advance;
   logic [pfc_pkg::SRC_W+2:0] src_x6;
   logic                 halve;
   pfc_pkg::div_in_type  div_in;
   logic                 div_valid;
   pfc_pkg::div_out_type div_out;

   rnd_stage_type rnd_ff, rnd_in;
   logic          rnd_valid_ff;
   mul_stage_type mul_ff, mul_in;
   logic          mul_valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // ratio below 6 is tgt < 6 * src (or src is zero): halve the divisor, set prescale
   always_comb begin
      src_x6 = {1'b0, req_chan.source_freq, 2'b00} + {2'b00, req_chan.source_freq, 1'b0};
      halve  = (req_chan.source_freq == '0)
            || ({3'b000, req_chan.target_freq} < src_x6);
      div_in.prescale = halve;
      div_in.divisor  = halve ? (req_chan.source_freq >> 1) : req_chan.source_freq;
      div_in.zero_src = (div_in.divisor == '0);
      div_in.dividend = req_chan.target_freq;
   end

   pfc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .in_data   (div_in),
      .out_valid (div_valid),
      .out_data  (div_out)
   );

   // round half up on the last decimal digit: (scaled + 5) / 10
   always_comb begin
      rnd_in.prescale = div_out.prescale;
      rnd_in.zero_src = div_out.zero_src;
      rnd_in.ratio    = div_out.ratio;
      rnd_in.sum      = {1'b0, div_out.scaled} + pfc_pkg::ROUND_ADD;
   end

   always_comb begin
      mul_in.prescale = rnd_ff.prescale;
      mul_in.zero_src = rnd_ff.zero_src;
      mul_in.ratio    = rnd_ff.ratio;
      mul_in.prod     = pfc_pkg::PROD_W'(rnd_ff.sum) * pfc_pkg::PROD_W'(pfc_pkg::RECIP_TEN);
   end

   always_comb begin
      if (mul_ff.zero_src) begin
         rsp_in = '0;
         rsp_in.zero_source_error = 1'b1;
      end else begin
         rsp_in.prescale_on       = mul_ff.prescale;
         rsp_in.n_factor          = mul_ff.ratio[pfc_pkg::N_W-1:0];
         rsp_in.k_fraction        = mul_ff.prod[pfc_pkg::RECIP_SHIFT +: pfc_pkg::K_W];
         rsp_in.n_out_of_range    = (mul_ff.ratio < pfc_pkg::N_LOW_LIMIT)
                                 || (mul_ff.ratio > pfc_pkg::N_HIGH_LIMIT);
         rsp_in.zero_source_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rnd_valid_ff <= div_valid;
         mul_valid_ff <= rnd_valid_ff;
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rnd_ff <= rnd_in;
         mul_ff <= mul_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.prescale_on       = rsp_ff.prescale_on;
   assign rsp_chan.n_factor          = rsp_ff.n_factor;
   assign rsp_chan.k_fraction        = rsp_ff.k_fraction;
   assign rsp_chan.n_out_of_range    = rsp_ff.n_out_of_range;
   assign rsp_chan.zero_source_error = rsp_ff.zero_source_error;

`ifndef SYNTH
   a_err_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.zero_source_error |->
         !rsp_ff.prescale_on && rsp_ff.n_factor == '0 && rsp_ff.k_fraction == '0
         && !rsp_ff.n_out_of_range)
      else $error("zero source response carries nonzero factors");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while pipeline is stalled");

   a_n_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.zero_source_error && !rsp_ff.n_out_of_range |->
         rsp_ff.n_factor >= 4'd6 && rsp_ff.n_factor <= 4'd12)
      else $error("n_factor outside range without flag");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.k_fraction <= (pfc_pkg::K_W'(1) << pfc_pkg::FRACTION_BITS))
      else $error("k_fraction above full scale");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled response changed");
`endif

endmodule
